// ===== hdl/lfpr_pkg.sv =====
// shared types, codes and the crc-16 byte update for the framed packet receiver
`default_nettype none
package lfpr_pkg;

	// parse phases
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CRCH = 3'd3;
	localparam logic [2:0] PH_CRCL = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	// framing bytes and crc polynomial
	localparam logic [7:0]  START_BYTE = 8'h02;
	localparam logic [7:0]  END_BYTE   = 8'h03;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [1:0] VERDICT_GOOD    = 2'd0;
	localparam logic [1:0] VERDICT_BAD_CRC = 2'd1;
	localparam logic [1:0] VERDICT_BAD_END = 2'd2;

	// one result word plus its valid flag
	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [1:0] verdict;
		logic [7:0] frame_length;
		logic       is_last;
	} result_t;

	// crc-16, msb first, one byte per call
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lfpr_parser.sv =====
// frame parser: phase, counts and running crc, one byte per step
`default_nettype none
module lfpr_parser (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                step,      // consume rx_byte this cycle
	input  wire [7:0]          rx_byte,
	output lfpr_pkg::result_t  res        // result caused by rx_byte, if any
);
	import lfpr_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [15:0] running_crc_q, running_crc_d;
	logic [15:0] received_crc_q, received_crc_d;
	logic [7:0]  left_dec;

	assign left_dec = bytes_left_q - 8'd1;

	// next state and result for the byte at hand
	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		frame_len_d    = frame_len_q;
		running_crc_d  = running_crc_q;
		received_crc_d = received_crc_q;
		res            = '0;
		unique case (phase_q)
			PH_LEN: begin
				frame_len_d   = rx_byte;
				bytes_left_d  = rx_byte;
				running_crc_d = '0;
				phase_d       = (rx_byte == 8'd0) ? PH_CRCH : PH_DATA;
			end
			PH_DATA: begin
				running_crc_d    = crc16_byte(running_crc_q, rx_byte);
				bytes_left_d     = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_CRCH;
				end
				res.valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = rx_byte;
			end
			PH_CRCH: begin
				received_crc_d = {rx_byte, 8'h00};
				phase_d        = PH_CRCL;
			end
			PH_CRCL: begin
				received_crc_d = {received_crc_q[15:8], rx_byte};
				phase_d        = PH_END;
			end
			PH_END: begin
				res.valid        = 1'b1;
				res.kind         = KIND_VERDICT;
				res.frame_length = frame_len_q;
				res.is_last      = 1'b1;
				priority if (rx_byte != END_BYTE) begin
					res.verdict = VERDICT_BAD_END;
				end else if (running_crc_q != received_crc_q) begin
					res.verdict = VERDICT_BAD_CRC;
				end else begin
					res.verdict = VERDICT_GOOD;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				// hunting, also covers the unused phase codes
				phase_d = PH_HUNT;
				if (rx_byte == START_BYTE) begin
					phase_d       = PH_LEN;
					running_crc_d = '0;
					bytes_left_d  = '0;
				end
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			bytes_left_q   <= '0;
			frame_len_q    <= '0;
			running_crc_q  <= '0;
			received_crc_q <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			bytes_left_q   <= bytes_left_d;
			frame_len_q    <= frame_len_d;
			running_crc_q  <= running_crc_d;
			received_crc_q <= received_crc_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lfpr_out_reg.sv =====
// result register driving the master-side stream
`default_nettype none
module lfpr_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,     // take res this cycle
	input  wire lfpr_pkg::result_t res,
	output logic               free,     // can take a word this cycle
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [23:0]        m_axis_tdata,  // payload_byte, verdict, frame_length, zero pad
	output logic               m_axis_tuser,  // kind
	output logic               m_axis_tlast   // is_last
);
	import lfpr_pkg::*;

	logic       valid_q;
	logic       kind_q;
	logic [7:0] payload_byte_q;
	logic [1:0] verdict_q;
	logic [7:0] frame_length_q;
	logic       is_last_q;

	assign free = !valid_q || m_axis_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload word
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q         <= res.kind;
			payload_byte_q <= res.payload_byte;
			verdict_q      <= res.verdict;
			frame_length_q <= res.frame_length;
			is_last_q      <= res.is_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {6'd0, frame_length_q, verdict_q, payload_byte_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = is_last_q;

endmodule
`default_nettype wire

// ===== hdl/length_framed_packet_receiver_crc16.sv =====
// top level of the length-framed packet receiver with crc-16 check
`default_nettype none
// Receives one serial byte per word and parses frames of start byte 2, length L,
// L payload bytes, crc high, crc low, end byte 3. Each payload byte comes out as a
// word with tuser 0; the end byte yields one verdict word with tuser 1 and tlast 1
// (verdict 0 good, 1 crc mismatch, 2 bad end byte) carrying the frame length. Bytes
// outside a frame other than 2 are dropped silently. One byte is taken every cycle
// unless output backpressure stalls it; a byte passes an input register, the parser
// (phase, counters and a byte-wide crc-16 update, poly 0x1021, init 0) and a result
// register, which offers its word. Output backpressure stalls input only when a
// result is due and the result register is full and not being read in that cycle.
module length_framed_packet_receiver_crc16 (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // payload_byte, verdict, frame_length, zero pad
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast    // is_last
);
	import lfpr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       out_free;
	result_t    res;

	// a held byte moves on when it makes no word or the result register has room
	assign step          = valid_s1 && (out_free || !res.valid);
	assign s_axis_tready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	lfpr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	lfpr_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && res.valid),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== tb/tb_length_framed_packet_receiver_crc16.sv =====
// self-checking testbench for the length-framed packet receiver with crc-16 check
module tb_length_framed_packet_receiver_crc16;
	timeunit 1ns;
	timeprecision 1ps;

	import lfpr_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BYTES   = 430;

	typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;
	typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_BOTH} flaw_t;
	typedef logic [7:0] byte_q_t[$];

	// one output word as seen on the master side
	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [1:0] verdict;
		logic [7:0] frame_length;
		logic       is_last;
	} rx_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // payload_byte, verdict, frame_length, zero pad
	logic        m_axis_tuser;   // kind
	logic        m_axis_tlast;   // is_last

	idle_mode_t mode;
	logic       stall_request;
	int         bytes_sent;
	int         quiet_cycles;

	// msb-first crc-16, poly 0x1021, one byte per call
	function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {d, 8'h00};
		repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		return c;
	endfunction

	// frame parser prediction and the queue of words still due
	class frame_scoreboard;
		rx_word_t    expected_q[$];
		logic [2:0]  phase;
		logic [7:0]  bytes_left;
		logic [7:0]  frame_len;
		logic [15:0] run_crc;
		logic [15:0] rx_crc;
		int          errors;
		int          payload_words;
		int          verdict_count[3];

		function new();
			phase = PH_HUNT;
			bytes_left = 8'h00;
			frame_len = 8'h00;
			run_crc = 16'h0000;
			rx_crc = 16'h0000;
			errors = 0;
			payload_words = 0;
			verdict_count = '{0, 0, 0};
		endfunction

		// advance the parser by one accepted byte
		function void note_byte(logic [7:0] b);
			rx_word_t w;
			w = '0;
			case (phase)
				PH_LEN: begin
					frame_len = b;
					bytes_left = b;
					run_crc = 16'h0000;
					phase = (b == 8'h00) ? PH_CRCH : PH_DATA;
				end
				PH_DATA: begin
					run_crc = crc_ccitt_byte(run_crc, b);
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'h00) phase = PH_CRCH;
					w.kind = KIND_PAYLOAD;
					w.payload_byte = b;
					expected_q.push_back(w);
				end
				PH_CRCH: begin
					rx_crc = {b, 8'h00};
					phase = PH_CRCL;
				end
				PH_CRCL: begin
					rx_crc[7:0] = b;
					phase = PH_END;
				end
				PH_END: begin
					// bad end byte wins over a crc mismatch
					if (b != END_BYTE) w.verdict = VERDICT_BAD_END;
					else if (run_crc != rx_crc) w.verdict = VERDICT_BAD_CRC;
					else w.verdict = VERDICT_GOOD;
					w.kind = KIND_VERDICT;
					w.frame_length = frame_len;
					w.is_last = 1'b1;
					expected_q.push_back(w);
					phase = PH_HUNT;
				end
				default: begin
					// hunting: only the start byte opens a frame
					phase = PH_HUNT;
					if (b == START_BYTE) begin
						phase = PH_LEN;
						run_crc = 16'h0000;
						bytes_left = 8'h00;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int exp_v, int got_v);
			if (exp_v != got_v) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
					got_v);
				errors++;
			end
		endfunction

		// compare one output word against the oldest expectation
		function void check_word(rx_word_t got);
			rx_word_t exp_w;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_w = expected_q.pop_front();
			compare_field("kind", exp_w.kind, got.kind);
			compare_field("payload_byte", exp_w.payload_byte, got.payload_byte);
			compare_field("verdict", exp_w.verdict, got.verdict);
			compare_field("frame_length", exp_w.frame_length, got.frame_length);
			compare_field("is_last", exp_w.is_last, got.is_last);
			if (got.kind == KIND_PAYLOAD) payload_words++;
			else if (got.verdict <= VERDICT_BAD_END) verdict_count[got.verdict]++;
		endfunction
	endclass

	frame_scoreboard sb;

	length_framed_packet_receiver_crc16 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int send_idle_pct(idle_mode_t m);
		case (m)
			IDLE_SEND_LIGHT: return 8;
			IDLE_SEND_HEAVY: return 57;
			default:         return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(idle_mode_t m);
		case (m)
			IDLE_SEND_LIGHT: return 57;
			IDLE_SEND_HEAVY: return 8;
			default:         return 0;
		endcase
	endfunction

	// offer one byte, with random gaps, until it is taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct(mode)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// start, length, payload, crc high, crc low, end
	task automatic send_frame(input byte_q_t body, input flaw_t flaw);
		logic [15:0] crc;
		logic [7:0]  tail;
		crc = 16'h0000;
		foreach (body[i]) crc = crc_ccitt_byte(crc, body[i]);
		if (flaw == FLAW_CRC || flaw == FLAW_BOTH) crc ^= 16'h0001 << $urandom_range(15);
		tail = END_BYTE;
		if (flaw == FLAW_END || flaw == FLAW_BOTH) begin
			tail = 8'($urandom_range(255));
			if (tail == END_BYTE) tail = ~tail;
		end
		send_byte(START_BYTE);
		send_byte(8'(body.size()));
		foreach (body[i]) send_byte(body[i]);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
		send_byte(tail);
	endtask

	task automatic send_random_frame(input int len, input flaw_t flaw);
		byte_q_t body;
		repeat (len) body.push_back(8'($urandom_range(255)));
		send_frame(body, flaw);
	endtask

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				wait (!stall_request);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(mode));
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
				m_axis_tdata[17:10], m_axis_tlast});
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** length_framed_packet_receiver_crc16: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		byte_q_t body;
		int      r;
		int      len;
		flaw_t   flaw;
		logic    long_done;
		sb = new();
		mode = IDLE_SEND_LIGHT;
		stall_request = 1'b0;
		bytes_sent = 0;
		long_done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise while hunting, empty frame, extremes, framing bytes as data
		send_byte(8'hFF);
		body.delete();
		send_frame(body, FLAW_NONE);
		body = '{8'hFF};
		send_frame(body, FLAW_NONE);
		body = '{START_BYTE, END_BYTE};
		send_frame(body, FLAW_CRC);
		body = '{8'h00};
		send_frame(body, FLAW_BOTH);

		// long receiver hold-off while a frame keeps coming
		stall_request = 1'b1;
		fork
			send_random_frame(24, FLAW_NONE);
			begin
				repeat (HOLD_CYCLES + 2) @(posedge clk);
				stall_request = 1'b0;
			end
		join

		// random frames with some noise and broken framing
		while (bytes_sent < RANDOM_BYTES || !long_done) begin
			if (bytes_sent < 110) mode = IDLE_SEND_LIGHT;
			else if (bytes_sent < 180) mode = IDLE_SEND_HEAVY;
			else mode = IDLE_NONE;
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
			r = $urandom_range(99);
			if (r < 70) flaw = FLAW_NONE;
			else if (r < 82) flaw = FLAW_CRC;
			else if (r < 94) flaw = FLAW_END;
			else flaw = FLAW_BOTH;
			if (mode == IDLE_NONE && !long_done) begin
				len = 255;
				long_done = 1'b1;
			end else if ($urandom_range(19) == 0) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(0, 8);
			end
			send_random_frame(len, flaw);
		end

		// drain
		s_axis_tvalid <= 1'b0;
		mode = IDLE_NONE;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes: %0d payload words, verdicts good %0d, bad crc %0d, bad end %0d",
			bytes_sent, sb.payload_words, sb.verdict_count[VERDICT_GOOD],
			sb.verdict_count[VERDICT_BAD_CRC], sb.verdict_count[VERDICT_BAD_END]);
		$display("idling on both sides, one long output hold-off, frame lengths 0 to 255");
		if (sb.errors == 0) begin
			$display("** length_framed_packet_receiver_crc16: PASSED **");
		end else begin
			$display("** length_framed_packet_receiver_crc16: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lfpr_pkg.sv
hdl/lfpr_parser.sv
hdl/lfpr_out_reg.sv
hdl/length_framed_packet_receiver_crc16.sv
tb/tb_length_framed_packet_receiver_crc16.sv
